// File: rtl/q8gmv_pkg.sv
// Package for the q8 group matvec row block: types, constants and the
// single precision multiply and add used by the datapath. No dependencies.
package q8gmv_pkg;

   localparam int GROUP_SIZE_DEF = 32;
   localparam int LANES_DEF = 8;
   localparam int MAX_GROUPS_DEF = 1024;

   localparam int GPR_W = 11;
   localparam int BASE_W = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS_PER_ROW = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_BASE = 4'd1;

   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_MUL_W,
      ST_MUL_A,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accum;
      logic last;
      logic conv;
      logic mul_w;
      logic mul_a;
      logic add;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sr;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [47:0] p;
      logic [47:0] q;
      logic [47:0] sq;
      logic [23:0] mant;
      logic        g;
      logic        stk;
      logic [7:0]  field;
      int          ea;
      int          eb;
      int          lead;
      int          er;
      int          sh;
      logic [31:0] res;
      sr = a[31] ^ b[31];
      res = 32'd0;
      if (is_nan(a)) begin
         res = a | FP_QUIET_BIT;
      end else if (is_nan(b)) begin
         res = b | FP_QUIET_BIT;
      end else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
         res = FP_DEFAULT_NAN;
      end else if (is_inf(a) || is_inf(b)) begin
         res = {sr, 8'hFF, 23'd0};
      end else begin
         ma = {a[30:23] != 8'd0, a[22:0]};
         mb = {b[30:23] != 8'd0, b[22:0]};
         ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
         eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
         p = ma * mb;
         if (p == 48'd0) begin
            res = {sr, 31'd0};
         end else begin
            lead = 0;
            for (int i = 0; i < 48; i++) begin
               if (p[i]) lead = i;
            end
            er = lead + ea + eb - 173;
            q = p << (47 - lead);
            if (er >= 255) begin
               res = {sr, 8'hFF, 23'd0};
            end else begin
               if (er >= 1) begin
                  mant = q[47:24];
                  g = q[23];
                  stk = |q[22:0];
                  field = 8'(er);
               end else begin
                  sh = 1 - er;
                  if (sh > 48) sh = 48;
                  sq = q >> sh;
                  mant = sq[47:24];
                  g = sq[23];
                  stk = (|sq[22:0]) | (|(q & ~({48{1'b1}} << sh)));
                  field = 8'd0;
               end
               res = {sr, field, mant[22:0]} + {31'd0, g & (stk | mant[0])};
            end
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] sml;
      logic [23:0] mbig;
      logic [23:0] msml;
      logic [26:0] xl;
      logic [26:0] xs;
      logic [26:0] xsh;
      logic [27:0] sum;
      logic [26:0] x;
      logic [7:0]  field;
      logic        inc;
      int          ebig;
      int          esml;
      int          d;
      int          e;
      int          lead;
      int          sh;
      logic [31:0] res;
      res = 32'd0;
      if (is_nan(a)) begin
         res = a | FP_QUIET_BIT;
      end else if (is_nan(b)) begin
         res = b | FP_QUIET_BIT;
      end else if (is_inf(a)) begin
         res = (is_inf(b) && (a[31] != b[31])) ? FP_DEFAULT_NAN : a;
      end else if (is_inf(b)) begin
         res = b;
      end else if (is_zero(a) && is_zero(b)) begin
         res = {a[31] & b[31], 31'd0};
      end else begin
         if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
         end else begin
            big = b;
            sml = a;
         end
         mbig = {big[30:23] != 8'd0, big[22:0]};
         msml = {sml[30:23] != 8'd0, sml[22:0]};
         ebig = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
         esml = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
         d = ebig - esml;
         if (d > 27) d = 27;
         xl = {mbig, 3'b000};
         xs = {msml, 3'b000};
         xsh = xs >> d;
         xsh[0] = xsh[0] | (|(xs & ~({27{1'b1}} << d)));
         if (big[31] == sml[31]) begin
            sum = {1'b0, xl} + {1'b0, xsh};
         end else begin
            sum = {1'b0, xl} - {1'b0, xsh};
         end
         if (sum == 28'd0) begin
            res = 32'd0;
         end else begin
            e = ebig;
            if (sum[27]) begin
               x = sum[27:1];
               x[0] = x[0] | sum[0];
               e = e + 1;
            end else begin
               lead = 0;
               for (int i = 0; i < 27; i++) begin
                  if (sum[i]) lead = i;
               end
               sh = 26 - lead;
               if (sh > e - 1) sh = e - 1;
               x = sum[26:0] << sh;
               e = e - sh;
            end
            if (e >= 255) begin
               res = {big[31], 8'hFF, 23'd0};
            end else begin
               field = x[26] ? 8'(e) : 8'd0;
               inc = x[2] & ((|x[1:0]) | x[3]);
               res = {big[31], field, x[25:3]} + {31'd0, inc};
            end
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/q8_group_matvec_row.sv
// Q8_0 group quantised matvec row engine: one beat of eight int8 pairs is
// taken per cycle while the controller is idle; after the last beat of a
// group it steps through convert, two scale multiplies and a float add.
// A finished row waits for a free output, then goes into the result register.
// Synchronous active high reset clears counters and sums; groups_per_row
// resets to 1, output_base to 0.
module q8_group_matvec_row #(
   parameter int GROUP_SIZE = q8gmv_pkg::GROUP_SIZE_DEF,
   parameter int LANES = q8gmv_pkg::LANES_DEF,
   parameter int MAX_GROUPS_PER_ROW = q8gmv_pkg::MAX_GROUPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [63:0]                       req_act_bytes,
   input  logic [63:0]                       req_wgt_bytes,
   input  logic [31:0]                       req_act_scale,
   input  logic [31:0]                       req_wgt_scale,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_row_sum,
   output logic [15:0]                       rsp_row_index,
   input  logic                              csr_write_en,
   input  logic [q8gmv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [q8gmv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import q8gmv_pkg::*;

   logic [GPR_W-1:0]  gpr_ff;
   logic [BASE_W-1:0] base_ff;
   logic              base_write;
   cmd_type           cmd;
   status_type        status;

   assign base_write = csr_write_en && (csr_index == CSR_OUTPUT_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_ff <= GPR_W'(1);
         base_ff <= '0;
      end else if (csr_write_en) begin
         if (csr_index == CSR_GROUPS_PER_ROW) gpr_ff <= csr_wdata[GPR_W-1:0];
         if (base_write) base_ff <= csr_wdata[BASE_W-1:0];
      end
   end

   q8gmv_ctrl #(
      .GROUP_SIZE(GROUP_SIZE),
      .LANES(LANES),
      .MAX_GROUPS_PER_ROW(MAX_GROUPS_PER_ROW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .groups_per_row(gpr_ff),
      .status(status),
      .cmd(cmd)
   );

   q8gmv_dpath #(
      .GROUP_SIZE(GROUP_SIZE),
      .LANES(LANES)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .act_bytes(req_act_bytes),
      .wgt_bytes(req_wgt_bytes),
      .act_scale(req_act_scale),
      .wgt_scale(req_wgt_scale),
      .output_base(base_ff),
      .base_write(base_write),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row_sum(rsp_row_sum),
      .rsp_row_index(rsp_row_index)
   );

endmodule

// File: rtl/q8gmv_ctrl.sv
// Controller for the q8 group matvec row block: chunk and group counting,
// sequencing of the float steps. Depends on q8gmv_pkg.
module q8gmv_ctrl #(
   parameter int GROUP_SIZE = q8gmv_pkg::GROUP_SIZE_DEF,
   parameter int LANES = q8gmv_pkg::LANES_DEF,
   parameter int MAX_GROUPS_PER_ROW = q8gmv_pkg::MAX_GROUPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [q8gmv_pkg::GPR_W-1:0]   groups_per_row,
   input  q8gmv_pkg::status_type         status,
   output q8gmv_pkg::cmd_type            cmd
);
   import q8gmv_pkg::*;

   localparam int CHUNKS = GROUP_SIZE / LANES;
   localparam int CHW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int GW = $clog2(MAX_GROUPS_PER_ROW + 1);
   localparam int CW = (GW > GPR_W) ? GW : GPR_W;

   state_type       state_ff, state_in;
   logic [CHW-1:0]  chunk_ff, chunk_in;
   logic [GW-1:0]   group_ff, group_in;
   logic [CW-1:0]   eff_groups;
   logic [CW-1:0]   group_next;
   logic            chunk_last;

   always_comb begin
      if (groups_per_row == '0) begin
         eff_groups = CW'(1);
      end else if (CW'(groups_per_row) > CW'(MAX_GROUPS_PER_ROW)) begin
         eff_groups = CW'(MAX_GROUPS_PER_ROW);
      end else begin
         eff_groups = CW'(groups_per_row);
      end
   end

   assign group_next = CW'(group_ff) + CW'(1);
   assign chunk_last = (chunk_ff == CHW'(CHUNKS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chunk_ff <= '0;
         group_ff <= '0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
         group_ff <= group_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      chunk_in = chunk_ff;
      group_in = group_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (chunk_last) begin
                  cmd.last = 1'b1;
                  chunk_in = '0;
                  state_in = ST_CONV;
               end else begin
                  chunk_in = chunk_ff + CHW'(1);
               end
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            cmd.mul_w = 1'b1;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            if (group_next >= eff_groups) begin
               group_in = '0;
               state_in = ST_EMIT;
            end else begin
               group_in = GW'(group_next);
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/q8gmv_dpath.sv
// Datapath for the q8 group matvec row block: int8 dot product, group sum,
// float convert, scale multiplies, row sum and result beat. Depends on q8gmv_pkg.
module q8gmv_dpath #(
   parameter int GROUP_SIZE = q8gmv_pkg::GROUP_SIZE_DEF,
   parameter int LANES = q8gmv_pkg::LANES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  q8gmv_pkg::cmd_type            cmd,
   output q8gmv_pkg::status_type         status,
   input  logic [63:0]                   act_bytes,
   input  logic [63:0]                   wgt_bytes,
   input  logic [31:0]                   act_scale,
   input  logic [31:0]                   wgt_scale,
   input  logic [q8gmv_pkg::BASE_W-1:0]  output_base,
   input  logic                          base_write,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_row_sum,
   output logic [q8gmv_pkg::BASE_W-1:0]  rsp_row_index
);
   import q8gmv_pkg::*;

   localparam int SW = $clog2(GROUP_SIZE) + 16;

   logic signed [SW-1:0] gsum_ff, gsum_in;
   logic signed [SW-1:0] hold_ff;
   logic signed [SW-1:0] dot;
   logic signed [SW-1:0] gsum_next;
   logic [31:0]          ascale_ff;
   logic [31:0]          wscale_ff;
   logic [31:0]          part_ff;
   logic [31:0]          row_ff, row_in;
   logic [BASE_W-1:0]    rows_ff, rows_in;
   logic                 vld_ff, vld_in;
   logic [31:0]          osum_ff;
   logic [BASE_W-1:0]    oidx_ff;
   logic [SW-1:0]        mag;
   logic [23:0]          m24;
   logic [31:0]          conv;
   int                   lead;

   always_comb begin
      dot = '0;
      for (int k = 0; k < LANES; k++) begin
         dot = dot + SW'($signed(act_bytes[8*(k%8) +: 8]) * $signed(wgt_bytes[8*(k%8) +: 8]));
      end
   end

   assign gsum_next = gsum_ff + dot;

   always_comb begin
      mag = hold_ff[SW-1] ? SW'(-hold_ff) : SW'(hold_ff);
      lead = 0;
      for (int i = 0; i < SW; i++) begin
         if (mag[i]) lead = i;
      end
      m24 = 24'(mag) << (23 - lead);
      if (mag == '0) begin
         conv = 32'd0;
      end else begin
         conv = {hold_ff[SW-1], 8'(127 + lead), m24[22:0]};
      end
   end

   always_comb begin
      gsum_in = gsum_ff;
      if (cmd.accum) begin
         gsum_in = cmd.last ? '0 : gsum_next;
      end
      row_in = row_ff;
      if (cmd.add) begin
         row_in = fp_add(row_ff, part_ff);
      end else if (cmd.emit) begin
         row_in = 32'd0;
      end
      rows_in = rows_ff;
      if (base_write) begin
         rows_in = '0;
      end else if (cmd.emit) begin
         rows_in = rows_ff + BASE_W'(1);
      end
      vld_in = vld_ff;
      if (cmd.emit) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gsum_ff <= '0;
         row_ff <= 32'd0;
         rows_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         gsum_ff <= gsum_in;
         row_ff <= row_in;
         rows_ff <= rows_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accum && cmd.last) begin
         hold_ff <= gsum_next;
         ascale_ff <= act_scale;
         wscale_ff <= wgt_scale;
      end
      if (cmd.conv) begin
         part_ff <= conv;
      end else if (cmd.mul_w) begin
         part_ff <= fp_mul(part_ff, wscale_ff);
      end else if (cmd.mul_a) begin
         part_ff <= fp_mul(part_ff, ascale_ff);
      end
      if (cmd.emit) begin
         osum_ff <= row_ff;
         oidx_ff <= output_base + rows_ff;
      end
   end

   assign status.out_free = !vld_ff || rsp_ready;
   assign rsp_valid = vld_ff;
   assign rsp_row_sum = osum_ff;
   assign rsp_row_index = oidx_ff;

endmodule
